>>> hw/rtl/mesh_interval_locate_top_assert.svh
// Assertion macros for the mesh interval locate block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MESH_INTERVAL_LOCATE_TOP_ASSERT_SVH
`define MESH_INTERVAL_LOCATE_TOP_ASSERT_SVH

// same-cycle implication
`define MIL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MIL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mil_pkg.sv
// Shared types and constants for the mesh interval locate block.
// No dependencies.
package mil_pkg;

  localparam int unsigned VALUE_W           = 32;
  localparam int unsigned DEF_MAX_ELEMENTS  = 256;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // table read address source
  typedef enum logic [2:0] {
    RD_FIRST,
    RD_LAST,
    RD_PROBE,
    RD_LOW,
    RD_HIGH
  } rd_sel_e;

  // how the result registers are set
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OOR,
    RES_TOP,
    RES_BOTTOM,
    RES_ZERO,
    RES_ONE,
    RES_DIV_INIT
  } res_e;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_lo;
    logic    cap_hi;
    res_e    set_res;
    logic    srch_init;
    logic    srch_upd;
    logic    div_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic oor;
    logic at_top;
    logic at_bot;
    logic cnt_zero;
    logic le_low;
    logic ge_high;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/mil_datapath.sv
// Datapath: breakpoint memory, limit registers, search counters, restoring
// divider and output register. Depends on mil_pkg and the assertion header.
`include "mesh_interval_locate_top_assert.svh"

module mil_datapath #(
  parameter int unsigned MAX_ELEMENTS  = mil_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned FRACTION_BITS = mil_pkg::DEF_FRACTION_BITS,
  localparam int unsigned AW  = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned EW  = $clog2(MAX_ELEMENTS),
  localparam int unsigned FW  = FRACTION_BITS + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [AW-1:0]                num_elements_i,
  input  logic                         mode_i,
  input  logic [AW-1:0]                entry_index_i,
  input  logic [mil_pkg::VALUE_W-1:0]  value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [EW-1:0]                element_index_o,
  output logic [FW-1:0]                local_position_o,
  output logic                         out_of_range_o,
  input  mil_pkg::cmd_t                cmd_i,
  output mil_pkg::status_t             status_o
);
  import mil_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_ELEMENTS + 2);
  localparam int unsigned CNTW = $clog2(FRACTION_BITS);
  localparam logic [FW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [VALUE_W-1:0] mem [MAX_ELEMENTS+1];
  logic [VALUE_W-1:0] rdata_q;
  logic [AW-1:0]      num_q;
  logic [AW-1:0]      n_q, n_eff;
  logic [VALUE_W-1:0] t_q, lo_q, hi_q;
  logic [CW-1:0]      first_q, count_q;
  logic [CW-1:0]      step_c, probe_c;
  logic [AW-1:0]      i_c, rd_addr;
  logic [VALUE_W-1:0] rem_q, den_q;
  logic [VALUE_W:0]   rem_sh;
  logic               rem_ge;
  logic [CNTW-1:0]    div_cnt_q;
  logic [FW-1:0]      res_frac_q, out_frac_q;
  logic [EW-1:0]      res_elem_q, out_elem_q;
  logic               res_oor_q, out_oor_q, out_valid_q;
  logic               is_query_q;
  logic               wr_en;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= AW'(1);
    end else if (cfg_valid_i) begin
      num_q <= num_elements_i;
    end
  end

  always_comb begin
    n_eff = num_q;
    if (num_q == '0) begin
      n_eff = AW'(1);
    end else if (num_q > AW'(MAX_ELEMENTS)) begin
      n_eff = AW'(MAX_ELEMENTS);
    end
  end

  assign wr_en = cmd_i.accept && (mode_i == MODE_LOAD) &&
                 (entry_index_i <= AW'(MAX_ELEMENTS));

  // search arithmetic
  assign step_c  = count_q >> 1;
  assign probe_c = first_q + step_c;

  always_comb begin
    if (first_q == '0) begin
      i_c = AW'(1);
    end else if (first_q > CW'(n_q)) begin
      i_c = n_q;
    end else begin
      i_c = first_q[AW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = n_q;
      RD_PROBE: rd_addr = probe_c[AW-1:0];
      RD_LOW:   rd_addr = i_c - AW'(1);
      RD_HIGH:  rd_addr = i_c;
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[entry_index_i] <= value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // divider step: remainder stays below the divisor
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t_q <= value_i;
      n_q <= n_eff;
    end
    if (cmd_i.cap_lo) begin
      lo_q <= rdata_q;
    end
    if (cmd_i.cap_hi) begin
      hi_q <= rdata_q;
    end
    if (cmd_i.srch_init) begin
      first_q <= '0;
      count_q <= CW'(n_q) + CW'(1);
    end else if (cmd_i.srch_upd) begin
      if (rdata_q < t_q) begin
        first_q <= probe_c + CW'(1);
        count_q <= count_q - step_c - CW'(1);
      end else begin
        count_q <= step_c;
      end
    end
    case (cmd_i.set_res)
      RES_OOR: begin
        res_oor_q  <= 1'b1;
        res_elem_q <= '0;
        res_frac_q <= '0;
      end
      RES_TOP: begin
        res_oor_q  <= 1'b0;
        res_elem_q <= EW'(n_q - AW'(1));
        res_frac_q <= ONE;
      end
      RES_BOTTOM: begin
        res_oor_q  <= 1'b0;
        res_elem_q <= '0;
        res_frac_q <= '0;
      end
      RES_ZERO: begin
        res_oor_q  <= 1'b0;
        res_elem_q <= EW'(i_c - AW'(1));
        res_frac_q <= '0;
      end
      RES_ONE: begin
        res_oor_q  <= 1'b0;
        res_elem_q <= EW'(i_c - AW'(1));
        res_frac_q <= ONE;
      end
      RES_DIV_INIT: begin
        res_oor_q  <= 1'b0;
        res_elem_q <= EW'(i_c - AW'(1));
        res_frac_q <= '0;
        rem_q      <= t_q - lo_q;
        den_q      <= hi_q - lo_q;
        div_cnt_q  <= '0;
      end
      default: begin
        if (cmd_i.div_step) begin
          res_frac_q <= {res_frac_q[FW-2:0], rem_ge};
          rem_q      <= rem_ge ? VALUE_W'(rem_sh - {1'b0, den_q}) : rem_sh[VALUE_W-1:0];
          div_cnt_q  <= div_cnt_q + CNTW'(1);
        end
      end
    endcase
    if (cmd_i.out_load) begin
      out_elem_q <= res_elem_q;
      out_frac_q <= res_frac_q;
      out_oor_q  <= res_oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      is_query_q  <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.accept) begin
        is_query_q <= (mode_i == MODE_QUERY);
      end
    end
  end

  assign status_o.is_query = (mode_i == MODE_QUERY);
  assign status_o.oor      = (t_q < lo_q) || (t_q > hi_q);
  assign status_o.at_top   = (t_q == hi_q);
  assign status_o.at_bot   = (t_q == lo_q);
  assign status_o.cnt_zero = (count_q == '0);
  assign status_o.le_low   = (t_q <= lo_q);
  assign status_o.ge_high  = (t_q >= hi_q);
  assign status_o.div_last = (div_cnt_q == CNTW'(FRACTION_BITS - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign element_index_o  = out_elem_q;
  assign local_position_o = out_frac_q;
  assign out_of_range_o   = out_oor_q;

  `MIL_ASSERT_IMP(a_oor_fields_zero, out_valid_q && out_oor_q,
    (out_elem_q == '0) && (out_frac_q == '0), "out of range result with non-zero fields")
  `MIL_ASSERT_IMP(a_frac_at_most_one, out_valid_q, out_frac_q <= ONE,
    "local position above 1.0")
  `MIL_ASSERT_IMP(a_div_rem_below_den, cmd_i.div_step, rem_q < den_q,
    "divider remainder not below divisor")
  `MIL_ASSERT_IMP(a_probe_in_table,
    cmd_i.rd_en && (cmd_i.rd_sel == RD_PROBE) && is_query_q,
    probe_c <= CW'(n_q), "search probe beyond last breakpoint")
  `MIL_ASSERT_NXT(a_load_shows_result, cmd_i.out_load, out_valid_q,
    "loaded result not presented")

endmodule

>>> hw/rtl/mil_ctrl.sv
// Controller state machine: sequences limit reads, binary search, segment
// reads, division and result hand-off. Depends on mil_pkg.
module mil_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mil_pkg::status_t status_i,
  output mil_pkg::cmd_t    cmd_o
);
  import mil_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIM0,
    S_LIM1,
    S_LIM2,
    S_CHECK,
    S_PROBE,
    S_CMP,
    S_SEG0,
    S_SEG1,
    S_SEG2,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o     = '0;
    cmd_o.rd_sel  = RD_FIRST;
    cmd_o.set_res = RES_NONE;
    state_d   = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.is_query) begin
          state_d = S_LIM0;
        end
      end
      S_LIM0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_FIRST;
        state_d      = S_LIM1;
      end
      S_LIM1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LAST;
        cmd_o.cap_lo = 1'b1;
        state_d      = S_LIM2;
      end
      S_LIM2: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        // upper end is tested before lower end
        if (status_i.oor) begin
          cmd_o.set_res = RES_OOR;
          state_d       = S_DONE;
        end else if (status_i.at_top) begin
          cmd_o.set_res = RES_TOP;
          state_d       = S_DONE;
        end else if (status_i.at_bot) begin
          cmd_o.set_res = RES_BOTTOM;
          state_d       = S_DONE;
        end else begin
          cmd_o.srch_init = 1'b1;
          state_d         = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status_i.cnt_zero) begin
          state_d = S_SEG0;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PROBE;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = S_PROBE;
      end
      S_SEG0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LOW;
        state_d      = S_SEG1;
      end
      S_SEG1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_HIGH;
        cmd_o.cap_lo = 1'b1;
        state_d      = S_SEG2;
      end
      S_SEG2: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = S_PREP;
      end
      S_PREP: begin
        if (status_i.le_low) begin
          cmd_o.set_res = RES_ZERO;
          state_d       = S_DONE;
        end else if (status_i.ge_high) begin
          cmd_o.set_res = RES_ONE;
          state_d       = S_DONE;
        end else begin
          cmd_o.set_res = RES_DIV_INIT;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> hw/rtl/mesh_interval_locate_top.sv
// Mesh interval locate: keeps ascending breakpoints, locates a query among
// them and returns the element and the local position within it.
//
// Input channel (in_valid_i/in_ready_o): mode_i = 0 loads value_i into
// breakpoint slot entry_index_i (slots above MAX_ELEMENTS are dropped) and
// gives no result; mode_i = 1 queries position value_i.
// Output channel (out_valid_o/out_ready_i): one item per query.
// Config channel (cfg_valid_i/cfg_ready_o): num_elements_i, always ready;
// write only while the block is idle.
// A load is written into the table when it is accepted. A query reads the
// table limits, makes up to ceil(log2(n+2)) binary search steps (9 for
// n = 256), reads the segment ends through the single table read port and
// runs the one-bit-a-cycle divider. Queries ending at a table limit or out
// of range skip the search and the division. One item is in work at a time.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a later query holds in its last state until the output
// register is free. Reset clears the control state and sets num_elements
// to 1; breakpoints are undefined until loaded.
module mesh_interval_locate_top #(
  parameter int unsigned MAX_ELEMENTS  = mil_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned FRACTION_BITS = mil_pkg::DEF_FRACTION_BITS,
  localparam int unsigned AW = $clog2(MAX_ELEMENTS + 1),
  localparam int unsigned EW = $clog2(MAX_ELEMENTS),
  localparam int unsigned FW = FRACTION_BITS + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [AW-1:0]               num_elements_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [AW-1:0]               entry_index_i,
  input  logic [mil_pkg::VALUE_W-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [EW-1:0]               element_index_o,
  output logic [FW-1:0]               local_position_o,
  output logic                        out_of_range_o
);
  import mil_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  mil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mil_datapath #(
    .MAX_ELEMENTS  (MAX_ELEMENTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .num_elements_i   (num_elements_i),
    .mode_i           (mode_i),
    .entry_index_i    (entry_index_i),
    .value_i          (value_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .element_index_o  (element_index_o),
    .local_position_o (local_position_o),
    .out_of_range_o   (out_of_range_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

>>> bench/mesh_interval_locate_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for mesh_interval_locate_top: breakpoint loads, interval queries,
// element count changes. Depends on mil_pkg and the RTL of the block only.
module mesh_interval_locate_top_tb;
  import mil_pkg::*;

  localparam int unsigned MAX_ELEM       = DEF_MAX_ELEMENTS;
  localparam int unsigned FRAC_BITS      = DEF_FRACTION_BITS;
  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned ITEM_TARGET    = 650;
  localparam int unsigned QUIET_CYCLES   = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned NUM_DIRECTED   = 26;
  localparam logic [FRAC_BITS:0] POS_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [7:0]         elem;
    logic [FRAC_BITS:0] pos;
    logic               oor;
  } loc_result_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_COUNT
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [8:0]  slot;
    logic [31:0] val;
    logic        typed;
    loc_result_t res;
  } dir_row_t;

  localparam loc_result_t NO_RES  = '0;
  localparam loc_result_t OOR_RES = '{8'd0, '0, 1'b1};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  num_elements_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = MODE_LOAD;
  logic [8:0]  entry_index_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  element_index_o;
  logic [FRAC_BITS:0] local_position_o;
  logic        out_of_range_o;

  // local copy of the block state
  logic [31:0] breakpoints [0:MAX_ELEM];
  logic [8:0]  elem_count = 9'd1;

  loc_result_t expected_locations [$];
  int unsigned mismatch_count = 0;
  int unsigned random_items   = 0;
  int unsigned snd_idle_pct   = 6;
  int unsigned rcv_idle_pct   = 80;
  int unsigned stall_cycles   = 0;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_LOAD,  9'd0,   32'h0001_0000, 1'b0, NO_RES},
    '{ROW_LOAD,  9'd1,   32'h0003_0000, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h0000_8000, 1'b1, OOR_RES},
    '{ROW_QUERY, 9'd0,   32'h0003_0001, 1'b1, OOR_RES},
    '{ROW_QUERY, 9'd0,   32'h0001_0000, 1'b1, '{8'd0, '0, 1'b0}},
    '{ROW_QUERY, 9'd0,   32'h0003_0000, 1'b1, '{8'd0, POS_ONE, 1'b0}},
    '{ROW_QUERY, 9'd0,   32'h0002_0000, 1'b0, NO_RES},
    '{ROW_LOAD,  9'd257, 32'h0000_0000, 1'b0, NO_RES},
    '{ROW_LOAD,  9'd511, 32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h0003_0000, 1'b1, '{8'd0, POS_ONE, 1'b0}},
    '{ROW_QUERY, 9'd0,   32'h0000_0000, 1'b1, OOR_RES},
    '{ROW_COUNT, 9'd0,   32'd4,         1'b0, NO_RES},
    '{ROW_LOAD,  9'd2,   32'h0005_0000, 1'b0, NO_RES},
    '{ROW_LOAD,  9'd3,   32'h0005_0000, 1'b0, NO_RES},
    '{ROW_LOAD,  9'd4,   32'hFFFF_FFFF, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'hFFFF_FFFF, 1'b1, '{8'd3, POS_ONE, 1'b0}},
    '{ROW_QUERY, 9'd0,   32'h0005_0000, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h8000_0000, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h0002_8000, 1'b0, NO_RES},
    '{ROW_LOAD,  9'd0,   32'h0000_0000, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h0000_0000, 1'b1, '{8'd0, '0, 1'b0}},
    '{ROW_LOAD,  9'd2,   32'h0000_1000, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h0002_0000, 1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h0004_0000, 1'b0, NO_RES},
    '{ROW_COUNT, 9'd0,   32'd0,         1'b0, NO_RES},
    '{ROW_QUERY, 9'd0,   32'h0002_0000, 1'b0, NO_RES}
  };

  mesh_interval_locate_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .num_elements_i   (num_elements_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .entry_index_i    (entry_index_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .element_index_o  (element_index_o),
    .local_position_o (local_position_o),
    .out_of_range_o   (out_of_range_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int unsigned eff_count();
    if (elem_count == 9'd0) return 1;
    if (elem_count > MAX_ELEM) return MAX_ELEM;
    return elem_count;
  endfunction

  function automatic loc_result_t locate_position(input logic [31:0] t);
    loc_result_t r;
    int unsigned n, first, span, half, probe, seg;
    logic [31:0] lo_lim, hi_lim, low, high;
    logic [31+FRAC_BITS:0] quot;
    r = '0;
    n = eff_count();
    lo_lim = breakpoints[0];
    hi_lim = breakpoints[n];
    if (t < lo_lim || t > hi_lim) begin
      r.oor = 1'b1;
    end else if (t == hi_lim) begin
      r.elem = 8'(n - 1);
      r.pos  = POS_ONE;
    end else if (t != lo_lim) begin
      // lower bound over entries 0..n
      first = 0;
      span  = n + 1;
      while (span > 0) begin
        half  = span / 2;
        probe = first + half;
        if (breakpoints[probe] < t) begin
          first = probe + 1;
          span  = span - half - 1;
        end else begin
          span = half;
        end
      end
      seg = (first < 1) ? 1 : ((first > n) ? n : first);
      low  = breakpoints[seg - 1];
      high = breakpoints[seg];
      r.elem = 8'(seg - 1);
      if (t <= low) begin
        r.pos = '0;
      end else if (t >= high) begin
        r.pos = POS_ONE;
      end else begin
        quot  = {t - low, {FRAC_BITS{1'b0}}} / (high - low);
        r.pos = quot[FRAC_BITS:0];
      end
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // one item on the input channel; prediction happens at acceptance
  task automatic send_item(input logic mode, input logic [8:0] slot, input logic [31:0] val,
                           input logic typed, input loc_result_t typed_res);
    if (random_items < ITEM_TARGET / 3) begin
      snd_idle_pct = 6;
      rcv_idle_pct = 80;
    end else if (random_items < 2 * ITEM_TARGET / 3) begin
      snd_idle_pct = 80;
      rcv_idle_pct = 6;
    end else begin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    entry_index_i <= slot;
    value_i       <= val;
    do @(posedge clk_i); while (!in_ready_o);
    if (mode == MODE_LOAD) begin
      if (slot <= MAX_ELEM) breakpoints[slot] = val;
    end else begin
      expected_locations.push_back(typed ? typed_res : locate_position(val));
    end
  endtask

  // count change only once the block has drained
  task automatic write_count(input logic [8:0] count);
    in_valid_i <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    num_elements_i <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    elem_count = count;
  endtask

  task automatic load_breakpoints(input int unsigned n);
    logic [31:0] v, gap_max;
    int unsigned i, pick;
    gap_max = 32'hF000_0000 / n;
    v = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'h0100_0000);
    for (i = 0; i <= n; i++) begin
      send_item(MODE_LOAD, 9'(i), v, 1'b0, NO_RES);
      random_items++;
      pick = $urandom_range(0, 19);
      // mostly ascending; now and then a repeat or an out-of-order entry
      if (pick == 0) v = $urandom;
      else if (pick != 1) v = v + $urandom_range(1, gap_max);
    end
  endtask

  task automatic run_phase(input logic reload, input int unsigned mixed);
    int unsigned n, j, pick;
    logic [31:0] lo, hi, t;
    logic [8:0]  slot;
    n = eff_count();
    if (reload) load_breakpoints(n);
    for (j = 0; j < mixed; j++) begin
      lo = breakpoints[0];
      hi = breakpoints[n];
      pick = $urandom_range(0, 19);
      if (pick >= 18) begin
        if (pick == 19) begin
          slot = 9'($urandom_range(MAX_ELEM + 1, 511));
        end else begin
          slot = 9'($urandom_range(0, MAX_ELEM));
          random_items++;
        end
        send_item(MODE_LOAD, slot, $urandom, 1'b0, NO_RES);
      end else begin
        case (pick)
          0: t = (lo == 32'd0) ? 32'd0 : $urandom_range(0, lo - 32'd1);
          1: t = (hi == 32'hFFFF_FFFF) ? hi : $urandom_range(hi + 32'd1, 32'hFFFF_FFFF);
          2, 3: t = breakpoints[$urandom_range(0, n)];
          4: t = breakpoints[$urandom_range(0, n)] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
          5: t = $urandom;
          default: t = $urandom_range(lo, hi);
        endcase
        send_item(MODE_QUERY, 9'($urandom_range(0, 511)), t, 1'b0, NO_RES);
        random_items++;
      end
    end
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);

  always @(posedge clk_i) begin : check_results
    loc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_locations.size() == 0) begin
        note_failure($sformatf("unexpected item: elem %0d pos %0d oor %0b",
                               element_index_o, local_position_o, out_of_range_o));
      end else begin
        want = expected_locations.pop_front();
        if (element_index_o !== want.elem || local_position_o !== want.pos ||
            out_of_range_o !== want.oor)
          note_failure($sformatf("mismatch: expected elem %0d pos %0d oor %0b, got %0d %0d %0b",
                                 want.elem, want.pos, want.oor,
                                 element_index_o, local_position_o, out_of_range_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("** mesh_interval_locate_top: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned k;
    logic [8:0]  count;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset count of one element applies to the first rows
    for (k = 0; k < NUM_DIRECTED; k++) begin
      case (directed_rows[k].kind)
        ROW_COUNT: write_count(directed_rows[k].val[8:0]);
        ROW_QUERY: send_item(MODE_QUERY, directed_rows[k].slot, directed_rows[k].val,
                             directed_rows[k].typed, directed_rows[k].res);
        default:   send_item(MODE_LOAD, directed_rows[k].slot, directed_rows[k].val,
                             directed_rows[k].typed, directed_rows[k].res);
      endcase
    end

    // full table first, so every slot is written before any later phase reads it
    write_count(9'd256);
    run_phase(1'b1, 40);
    write_count(9'd511);
    run_phase(1'b0, 40);
    while (random_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       count = 9'd0;
        1:       count = 9'($urandom_range(MAX_ELEM + 1, 511));
        2:       count = 9'd1;
        default: count = 9'($urandom_range(2, 24));
      endcase
      write_count(count);
      run_phase(count <= MAX_ELEM, 30);
    end

    in_valid_i <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** mesh_interval_locate_top: PASSED **");
    end else begin
      $display("** mesh_interval_locate_top: FAILED **");
    end
    $finish;
  end

endmodule
